// File: design/efr_pkg.sv
package efr_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLengthLimit = 3'd0,
    CfgTypeA       = 3'd1,
    CfgTypeB       = 3'd2,
    CfgTypeC       = 3'd3,
    CfgTypeD       = 3'd4
  } cfg_idx_e;

  localparam int unsigned NumTypes = 4;

  // register reset values
  localparam logic [7:0] LengthLimitRst = 8'd200;
  localparam logic [7:0] TypeARst       = 8'h92;
  localparam logic [7:0] TypeBRst       = 8'h95;
  localparam logic [7:0] TypeCRst       = 8'h88;
  localparam logic [7:0] TypeDRst       = 8'h97;

  // event codes on the result channel
  typedef enum logic [2:0] {
    EvPayload  = 3'd0,
    EvGood     = 3'd1,
    EvBadSum   = 3'd2,
    EvNoStart  = 3'd3,
    EvLenErr   = 3'd4,
    EvFrameErr = 3'd5,
    EvUnkType  = 3'd6
  } event_e;

  typedef struct packed {
    logic [7:0]                length_limit;
    logic [NumTypes-1:0][7:0]  types;
  } cfg_t;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  frame_kind;
    logic [7:0]  data_value;
    logic [7:0]  payload_index;
    logic        last_data;
    logic [15:0] length_value;
  } result_t;

endpackage

// File: design/efr_if.sv
interface efr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface efr_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  frame_kind;
  logic [7:0]  data_value;
  logic [7:0]  payload_index;
  logic        last_data;
  logic [15:0] length_value;

  modport source (output valid, output event_res, output frame_kind, output data_value,
                  output payload_index, output last_data, output length_value,
                  input ready);
  modport sink (input valid, input event_res, input frame_kind, input data_value,
                input payload_index, input last_data, input length_value,
                output ready);
endinterface

interface efr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/efr_cfg.sv
module efr_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  efr_cfg_if.sink       cfg_i,
  output efr_pkg::cfg_t cfg_o
);

  efr_pkg::cfg_t cfg_q;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.length_limit <= efr_pkg::LengthLimitRst;
      cfg_q.types[0]     <= efr_pkg::TypeARst;
      cfg_q.types[1]     <= efr_pkg::TypeBRst;
      cfg_q.types[2]     <= efr_pkg::TypeCRst;
      cfg_q.types[3]     <= efr_pkg::TypeDRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        efr_pkg::CfgLengthLimit: cfg_q.length_limit <= cfg_i.data;
        efr_pkg::CfgTypeA:       cfg_q.types[0] <= cfg_i.data;
        efr_pkg::CfgTypeB:       cfg_q.types[1] <= cfg_i.data;
        efr_pkg::CfgTypeC:       cfg_q.types[2] <= cfg_i.data;
        efr_pkg::CfgTypeD:       cfg_q.types[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/efr_parser.sv
module efr_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic             adv_i,
  input  logic [7:0]       byte_i,
  input  efr_pkg::cfg_t    cfg_i,
  output logic             res_v_o,
  output efr_pkg::result_t res_o
);

  localparam logic [7:0] EscByte   = 8'h7D;
  localparam logic [7:0] StartByte = 8'h7E;
  localparam logic [7:0] EscXor    = 8'h20;
  localparam logic [7:0] ErrType   = 8'hFE;

  localparam logic [8:0] PosStart   = 9'd0;
  localparam logic [8:0] PosLenHi   = 9'd1;
  localparam logic [8:0] PosLenLo   = 9'd2;
  localparam logic [8:0] PosType    = 9'd3;
  localparam logic [8:0] PosPayload = 9'd4;

  logic        esc_q, esc_d;
  logic [8:0]  pos_q, pos_d;
  logic [15:0] size_q, size_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  sum_q, sum_d;

  logic        is_esc;
  logic [7:0]  c;
  logic [15:0] size_lo;
  logic        type_ok;
  logic [16:0] end_pos;
  logic [16:0] last_pos;
  logic [16:0] pos_ext;
  logic [8:0]  pos_off;
  logic        hit;
  efr_pkg::result_t res;

  // unescape
  assign is_esc  = (byte_i == EscByte);
  assign c       = esc_q ? (byte_i ^ EscXor) : byte_i;
  assign size_lo = {size_q[15:8], c};

  // accepted type match
  always_comb begin
    type_ok = 1'b0;
    for (int i = 0; i < efr_pkg::NumTypes; i++) begin
      if (c == cfg_i.types[i]) type_ok = 1'b1;
    end
  end

  // frame end and last payload position
  assign end_pos  = {1'b0, size_q} + 17'd3;
  assign last_pos = {1'b0, size_q} + 17'd2;
  assign pos_ext  = {8'b0, pos_q};
  assign pos_off  = pos_q - PosPayload;

  // next state and result
  always_comb begin
    esc_d  = esc_q;
    pos_d  = pos_q;
    size_d = size_q;
    type_d = type_q;
    sum_d  = sum_q;
    hit    = 1'b0;
    res    = '0;
    if (is_esc) begin
      esc_d = 1'b1;
    end else begin
      esc_d = 1'b0;
      case (pos_q)
        PosStart: begin
          sum_d  = '0;
          type_d = '0;
          size_d = '0;
          if (c == StartByte) begin
            pos_d = PosLenHi;
          end else begin
            hit            = 1'b1;
            res.event_res  = efr_pkg::EvNoStart;
            res.data_value = c;
          end
        end
        PosLenHi: begin
          size_d = {c, 8'h00};
          pos_d  = PosLenLo;
        end
        PosLenLo: begin
          size_d = size_lo;
          if (size_lo == 16'd0 || size_lo >= {8'b0, cfg_i.length_limit}) begin
            pos_d            = PosStart;
            hit              = 1'b1;
            res.event_res    = efr_pkg::EvLenErr;
            res.length_value = size_lo;
          end else begin
            pos_d = PosType;
          end
        end
        PosType: begin
          type_d = c;
          if (type_ok) begin
            sum_d = sum_q + c;
            pos_d = PosPayload;
          end else begin
            pos_d            = PosStart;
            hit              = 1'b1;
            res.event_res    = (c == ErrType) ? efr_pkg::EvFrameErr : efr_pkg::EvUnkType;
            res.frame_kind   = c;
            res.data_value   = c;
            res.length_value = size_q;
          end
        end
        default: begin
          hit              = 1'b1;
          res.frame_kind   = type_q;
          res.data_value   = c;
          res.length_value = size_q;
          if (pos_ext >= end_pos) begin
            // checksum byte closes the frame
            pos_d         = PosStart;
            res.event_res = (c == ~sum_q) ? efr_pkg::EvGood : efr_pkg::EvBadSum;
          end else begin
            sum_d             = sum_q + c;
            pos_d             = pos_q + 9'd1;
            res.event_res     = efr_pkg::EvPayload;
            res.payload_index = pos_off[7:0];
            res.last_data     = (pos_ext == last_pos);
          end
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= 1'b0;
      pos_q  <= PosStart;
      size_q <= '0;
      type_q <= '0;
      sum_q  <= '0;
    end else if (adv_i) begin
      esc_q  <= esc_d;
      pos_q  <= pos_d;
      size_q <= size_d;
      type_q <= type_d;
      sum_q  <= sum_d;
    end
  end

  assign res_v_o = valid_i && hit;
  assign res_o   = res;

  // any frame-ending or error event returns to hunting for a start byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_v_o && res_o.event_res != efr_pkg::EvPayload |=> pos_q == PosStart)
    else $error("parser did not return to start after a closing event");

  // a payload index always lies inside the announced length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_o && res_o.event_res == efr_pkg::EvPayload |->
      {8'b0, res_o.payload_index} < res_o.length_value)
    else $error("payload index beyond frame length");

  // inside a frame body the position never runs past the checksum byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q >= PosPayload |-> {8'b0, pos_q} <= {1'b0, size_q} + 17'd3)
    else $error("byte position past checksum");

  // an escape byte arms the mark and produces nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && is_esc |-> !res_v_o ##1 esc_q)
    else $error("escape byte handled wrongly");

endmodule

// File: design/efr_out_reg.sv
module efr_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             res_v_i,
  input  efr_pkg::result_t res_i,
  output logic             free_o,
  efr_event_if.source      evt_o
);

  logic             valid_q;
  efr_pkg::result_t res_q;

  // register is free when empty or its transfer completes now
  assign free_o = !valid_q || evt_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_v_i;
    end else if (evt_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i && res_v_i) begin
      res_q <= res_i;
    end
  end

  assign evt_o.valid         = valid_q;
  assign evt_o.event_res     = res_q.event_res;
  assign evt_o.frame_kind    = res_q.frame_kind;
  assign evt_o.data_value    = res_q.data_value;
  assign evt_o.payload_index = res_q.payload_index;
  assign evt_o.last_data     = res_q.last_data;
  assign evt_o.length_value  = res_q.length_value;

endmodule

// File: design/escaped_frame_receiver_top.sv
// channel   dir  payload                                            role
// rx_i      in   rx_byte                                            raw bytes from the link
// evt_o     out  event_res frame_kind data_value payload_index      payload bytes and
//                last_data length_value                             frame events
// cfg_i     in   index data                                         register writes
//
// one byte per cycle sustained while evt_o is not stalled; an event reaches evt_o after its byte's
// transfer through the input register, one pass of parse logic and the result register
// escape bytes, and header bytes that pass their checks, give no event
// a stall on evt_o holds the input register, and rx_i.ready drops only while both are full
// reset clears parser state and loads the register defaults; no clearing pass
module escaped_frame_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  efr_byte_if.sink    rx_i,
  efr_event_if.source evt_o,
  efr_cfg_if.sink     cfg_i
);

  efr_pkg::cfg_t    cfg;
  efr_pkg::result_t res;
  logic             res_v;
  logic             out_free;
  logic             adv;
  logic             stage_v_q;
  logic [7:0]       stage_byte_q;

  efr_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // input register
  assign adv        = stage_v_q && out_free;
  assign rx_i.ready = !stage_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else if (rx_i.ready) begin
      stage_v_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      stage_byte_q <= rx_i.rx_byte;
    end
  end

  efr_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_v_q),
    .adv_i   (adv),
    .byte_i  (stage_byte_q),
    .cfg_i   (cfg),
    .res_v_o (res_v),
    .res_o   (res)
  );

  efr_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .res_v_i (res_v),
    .res_i   (res),
    .free_o  (out_free),
    .evt_o   (evt_o)
  );

endmodule

// File: tb/escaped_frame_receiver_top_tb.sv
`timescale 1ns / 100ps

module escaped_frame_receiver_top_tb;

  localparam logic [7:0] EscByte   = 8'h7D;
  localparam logic [7:0] StartByte = 8'h7E;
  localparam logic [7:0] EscXor    = 8'h20;
  localparam logic [7:0] ErrType   = 8'hFE;

  localparam int StallLimit  = 5000;
  localparam int DrainCycles = 8;
  localparam int NumPhases   = 6;

  localparam efr_pkg::result_t NoEvent = '0;

  // one byte to send, with an optional hand-written expectation
  typedef struct {
    logic [7:0]       raw;
    bit               typed;
    efr_pkg::result_t res;
  } row_t;

  logic clk;
  logic rst_n;

  efr_byte_if  rx_if ();
  efr_event_if evt_if ();
  efr_cfg_if   cfg_if ();

  escaped_frame_receiver_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .evt_o  (evt_if),
    .cfg_i  (cfg_if)
  );

  // register copies seen by the parser model
  logic [7:0] limit_reg = efr_pkg::LengthLimitRst;
  logic [7:0] type_regs [efr_pkg::NumTypes] = '{efr_pkg::TypeARst, efr_pkg::TypeBRst,
                                                efr_pkg::TypeCRst, efr_pkg::TypeDRst};

  // parser model state
  bit         esc_armed = 1'b0;
  logic [8:0] parse_pos = '0;
  logic [15:0] frame_len = '0;
  logic [7:0] frame_type = '0;
  logic [7:0] frame_sum = '0;

  // register values used to build frames in the current phase
  logic [7:0] gen_limit = efr_pkg::LengthLimitRst;
  logic [7:0] gen_types [efr_pkg::NumTypes] = '{efr_pkg::TypeARst, efr_pkg::TypeBRst,
                                                efr_pkg::TypeCRst, efr_pkg::TypeDRst};

  efr_pkg::result_t expected_events [$];
  row_t    row_tags [$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      sent_items = 0;
  int      stall_left = 0;
  bit      idle_en = 1'b1;

  // directed bytes, starting from reset register values
  row_t directed_rows [27] = '{
    '{8'h00, 1'b1, '{efr_pkg::EvNoStart, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000}},
    '{8'hFF, 1'b1, '{efr_pkg::EvNoStart, 8'h00, 8'hFF, 8'h00, 1'b0, 16'h0000}},
    // zero length
    '{8'h7E, 1'b0, NoEvent},
    '{8'h00, 1'b0, NoEvent},
    '{8'h00, 1'b1, '{efr_pkg::EvLenErr, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000}},
    // largest length
    '{8'h7E, 1'b0, NoEvent},
    '{8'hFF, 1'b0, NoEvent},
    '{8'hFF, 1'b1, '{efr_pkg::EvLenErr, 8'h00, 8'h00, 8'h00, 1'b0, 16'hFFFF}},
    // double escape then escaped start, length one frame
    '{8'h7D, 1'b0, NoEvent},
    '{8'h7D, 1'b0, NoEvent},
    '{8'h5E, 1'b0, NoEvent},
    '{8'h00, 1'b0, NoEvent},
    '{8'h01, 1'b0, NoEvent},
    '{8'h92, 1'b0, NoEvent},
    '{8'h6D, 1'b0, NoEvent},
    // frame error type
    '{8'h7E, 1'b0, NoEvent},
    '{8'h00, 1'b0, NoEvent},
    '{8'h02, 1'b0, NoEvent},
    '{8'hFE, 1'b1, '{efr_pkg::EvFrameErr, 8'hFE, 8'hFE, 8'h00, 1'b0, 16'h0002}},
    // start byte as data and an escaped payload byte
    '{8'h7E, 1'b0, NoEvent},
    '{8'h00, 1'b0, NoEvent},
    '{8'h03, 1'b0, NoEvent},
    '{8'h95, 1'b0, NoEvent},
    '{8'h7E, 1'b0, NoEvent},
    '{8'h7D, 1'b0, NoEvent},
    '{8'h5D, 1'b0, NoEvent},
    '{8'h6F, 1'b0, NoEvent}
  };

  // register settings per random phase; phases 3 and 5 are drawn at run time
  logic [7:0] phase_set [NumPhases][5] = '{
    '{8'd255, 8'h00, 8'hFF, 8'h7E, 8'h7D},
    '{8'd2,   8'h92, 8'hFE, 8'h95, 8'h88},
    '{8'd1,   8'h11, 8'h22, 8'h33, 8'h44},
    '{8'd16,  8'h00, 8'h00, 8'h00, 8'h00},
    '{8'd200, 8'h92, 8'h95, 8'h88, 8'h97},
    '{8'd100, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  int phase_items [NumPhases] = '{260, 120, 60, 260, 250, 150};

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit type_ok(input logic [7:0] t);
    return t == type_regs[0] || t == type_regs[1] || t == type_regs[2] || t == type_regs[3];
  endfunction

  // parser model: one raw byte in, zero or one event out
  function automatic bit predict_event(input logic [7:0] raw, output efr_pkg::result_t ev);
    logic [7:0] c;
    c = raw;
    ev = NoEvent;
    if (c == EscByte) begin
      esc_armed = 1'b1;
      return 1'b0;
    end
    if (esc_armed) begin
      c = c ^ EscXor;
      esc_armed = 1'b0;
    end
    if (parse_pos == 0) begin
      frame_type = '0;
      frame_len = '0;
    end
    case (parse_pos)
      9'd0: begin
        frame_sum = '0;
        if (c == StartByte) begin
          parse_pos = 9'd1;
          return 1'b0;
        end
        ev.event_res = efr_pkg::EvNoStart;
        ev.data_value = c;
        return 1'b1;
      end
      9'd1: begin
        frame_len = {c, 8'h00};
        parse_pos = 9'd2;
        return 1'b0;
      end
      9'd2: begin
        frame_len[7:0] = c;
        if (frame_len == 0 || frame_len >= {8'h00, limit_reg}) begin
          parse_pos = 9'd0;
          ev.event_res = efr_pkg::EvLenErr;
          ev.length_value = frame_len;
          return 1'b1;
        end
        parse_pos = 9'd3;
        return 1'b0;
      end
      9'd3: begin
        frame_type = c;
        if (type_ok(c)) begin
          frame_sum = frame_sum + c;
          parse_pos = 9'd4;
          return 1'b0;
        end
        parse_pos = 9'd0;
        ev.event_res = (c == ErrType) ? efr_pkg::EvFrameErr : efr_pkg::EvUnkType;
        ev.frame_kind = c;
        ev.data_value = c;
        ev.length_value = frame_len;
        return 1'b1;
      end
      default: ;
    endcase
    // checksum byte closes the frame
    if (int'(parse_pos) >= int'(frame_len) + 3) begin
      parse_pos = 9'd0;
      ev.event_res = (c == 8'hFF - frame_sum) ? efr_pkg::EvGood : efr_pkg::EvBadSum;
      ev.frame_kind = frame_type;
      ev.data_value = c;
      ev.length_value = frame_len;
      return 1'b1;
    end
    // payload byte
    ev.event_res = efr_pkg::EvPayload;
    ev.frame_kind = frame_type;
    ev.data_value = c;
    ev.payload_index = 8'(parse_pos - 9'd4);
    ev.last_data = (int'(parse_pos) == int'(frame_len) + 2);
    ev.length_value = frame_len;
    frame_sum = frame_sum + c;
    parse_pos = parse_pos + 9'd1;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // track transfers on all channels, predict and compare events
  always @(posedge clk) begin : track_events
    row_t             tag;
    efr_pkg::result_t pred;
    efr_pkg::result_t got;
    efr_pkg::result_t want;
    bit               produced;
    if (rst_n) begin
      if (rx_if.valid && rx_if.ready) begin
        tag = row_tags.pop_front();
        produced = predict_event(rx_if.rx_byte, pred);
        if (tag.typed) expected_events.push_back(tag.res);
        else if (produced) expected_events.push_back(pred);
      end
      if (evt_if.valid && evt_if.ready) begin
        got.event_res = efr_pkg::event_e'(evt_if.event_res);
        got.frame_kind = evt_if.frame_kind;
        got.data_value = evt_if.data_value;
        got.payload_index = evt_if.payload_index;
        got.last_data = evt_if.last_data;
        got.length_value = evt_if.length_value;
        if (expected_events.size() == 0) begin
          $error("event transfer with nothing expected: event_res %0d", got.event_res);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", 16'(want.event_res), 16'(got.event_res));
          check_field("frame_kind", 16'(want.frame_kind), 16'(got.frame_kind));
          check_field("data_value", 16'(want.data_value), 16'(got.data_value));
          check_field("payload_index", 16'(want.payload_index), 16'(got.payload_index));
          check_field("last_data", 16'(want.last_data), 16'(got.last_data));
          check_field("length_value", want.length_value, got.length_value);
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (efr_pkg::cfg_idx_e'(cfg_if.index))
          efr_pkg::CfgLengthLimit: limit_reg = cfg_if.data;
          efr_pkg::CfgTypeA:       type_regs[0] = cfg_if.data;
          efr_pkg::CfgTypeB:       type_regs[1] = cfg_if.data;
          efr_pkg::CfgTypeC:       type_regs[2] = cfg_if.data;
          efr_pkg::CfgTypeD:       type_regs[3] = cfg_if.data;
          default: ;
        endcase
      end
      if ((rx_if.valid && rx_if.ready) || (evt_if.valid && evt_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // event sink with random stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      evt_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      evt_if.ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      evt_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    while (idle_cycles < StallLimit) @(posedge clk);
    $display("FAIL escaped_frame_receiver_top");
    $finish;
  end

  task automatic send_byte(input row_t row);
    int gap;
    gap = pick_gap();
    row_tags.push_back(row);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= row.raw;
    sent_items++;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
  endtask

  task automatic send_plain(input logic [7:0] b);
    row_t row;
    row.raw = b;
    row.typed = 1'b0;
    row.res = NoEvent;
    send_byte(row);
  endtask

  // byte inside a frame, escaped where needed and now and then without need
  task automatic put_byte(input logic [7:0] v);
    if (v == EscByte || (v == StartByte && $urandom_range(0, 1) == 1) ||
        (v != 8'h5D && $urandom_range(0, 24) == 0)) begin
      send_plain(EscByte);
      if (v != 8'h5D && $urandom_range(0, 30) == 0) send_plain(EscByte);
      send_plain(v ^ EscXor);
    end else begin
      send_plain(v);
    end
  endtask

  // one frame, mostly well formed, otherwise noise or a broken frame
  task automatic send_frame();
    int          mode;
    int          hi;
    int          len;
    int          n;
    int          stop_at;
    logic [15:0] len_f;
    logic [7:0]  kind_b;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [7:0]  chk;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      repeat ($urandom_range(1, 4)) send_plain(8'($urandom()));
      return;
    end
    hi = (gen_limit < 2) ? 8 : int'(gen_limit) - 1;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, hi)
                                      : $urandom_range(1, (hi < 12) ? hi : 12);
    len_f = 16'(len);
    if (mode < 14) len_f = ($urandom_range(0, 1) == 1) ? 16'h0000
                                                       : 16'($urandom_range(gen_limit, 65535));
    kind_b = gen_types[$urandom_range(0, efr_pkg::NumTypes - 1)];
    if (mode >= 14 && mode < 20) kind_b = ($urandom_range(0, 1) == 1) ? ErrType : 8'($urandom());
    // start byte, rarely in escaped form
    if ($urandom_range(0, 15) == 0) begin
      send_plain(EscByte);
      send_plain(StartByte ^ EscXor);
    end else begin
      send_plain(StartByte);
    end
    put_byte(len_f[15:8]);
    put_byte(len_f[7:0]);
    if (mode < 14) return;
    put_byte(kind_b);
    if (mode < 20) return;
    sum = kind_b;
    stop_at = (mode < 25) ? $urandom_range(0, len - 1) : len - 1;
    for (n = 0; n < stop_at; n++) begin
      case ($urandom_range(0, 9))
        0:       b = EscByte;
        1:       b = StartByte;
        default: b = 8'($urandom());
      endcase
      sum = sum + b;
      put_byte(b);
    end
    if (mode < 25) return;
    chk = 8'hFF - sum;
    if (mode < 35) chk = chk ^ 8'($urandom_range(1, 255));
    put_byte(chk);
  endtask

  // let the pipeline empty before touching registers
  task automatic wait_idle();
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] vals [5]);
    efr_pkg::cfg_idx_e idx [5] = '{efr_pkg::CfgLengthLimit, efr_pkg::CfgTypeA,
                                   efr_pkg::CfgTypeB, efr_pkg::CfgTypeC, efr_pkg::CfgTypeD};
    for (int i = 0; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data <= vals[i];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
    end
    cfg_if.valid <= 1'b0;
    gen_limit = vals[0];
    for (int i = 0; i < efr_pkg::NumTypes; i++) gen_types[i] = vals[i + 1];
  endtask

  // main sequence
  initial begin
    int phase_end;
    rst_n <= 1'b0;
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= efr_pkg::CfgLengthLimit;
    cfg_if.data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed bytes at reset settings
    foreach (directed_rows[i]) send_byte(directed_rows[i]);
    rx_if.valid <= 1'b0;

    // random phases, each under its own register settings
    for (int p = 0; p < NumPhases; p++) begin
      if (p == 3) begin
        phase_set[p][0] = 8'($urandom_range(3, 64));
        for (int k = 1; k < 5; k++) phase_set[p][k] = 8'($urandom());
      end
      if (p == 5) begin
        phase_set[p][0] = 8'($urandom_range(2, 255));
        for (int k = 1; k < 5; k++) phase_set[p][k] = 8'($urandom());
      end
      wait_idle();
      apply_settings(phase_set[p]);
      phase_end = sent_items + phase_items[p];
      while (sent_items < phase_end) begin
        idle_en = ($urandom_range(0, 4) != 0);
        send_frame();
      end
      rx_if.valid <= 1'b0;
    end

    // drain
    idle_en = 1'b1;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS escaped_frame_receiver_top");
    end else begin
      $display("FAIL escaped_frame_receiver_top");
    end
    $finish;
  end

endmodule
